/* rtl/tfsp_pkg.sv */
package tfsp_pkg;

    localparam int SLOTS_DEF  = 4;
    localparam int MAX_RES    = 4;
    localparam int RES_W      = 3;
    localparam int REM_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_DATA_W-1:0] PULSE_ON_RST     = 16'd150;
    localparam logic [CFG_DATA_W-1:0] PULSE_PERIOD_RST = 16'd280;
    localparam logic [CFG_DATA_W-1:0] FLASH_TOTAL_RST  = 16'd560;

    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_ON     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_TOTAL  = 2'd2;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_RENDER = 2'd1,
        OP_QUERY  = 2'd2
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CLAIM,
        ST_QDONE,
        ST_RSTEP,
        ST_RWAIT,
        ST_RDONE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  key_usage;
        logic        turn_on;
        logic [31:0] now_ms;
    } tfsp_req_t;

    typedef struct packed {
        logic [1:0] slot_index;
        logic [7:0] key_usage_out;
        logic       lit;
        logic       green;
        logic       any_active;
        logic       last;
    } tfsp_rsp_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic claim;
        logic query_done;
        logic rend_step;
        logic rend_rec;
        logic rend_done;
        logic emit;
    } tfsp_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       cnt_last;
        logic       survivor;
        logic       rem_done;
        logic       out_free;
        logic       emit_last;
    } tfsp_sts_t;

endpackage

/* rtl/tfsp_rem.sv */
module tfsp_rem (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [tfsp_pkg::REM_W-1:0] dividend,
    input  logic [tfsp_pkg::REM_W-1:0] divisor,
    output logic                       done,
    output logic [tfsp_pkg::REM_W-1:0] rem
);
    import tfsp_pkg::*;

    localparam int STEP_W = $clog2(REM_W);

    logic [REM_W-1:0]  r_reg;
    logic [REM_W-1:0]  r_next;
    logic [REM_W-1:0]  d_reg;
    logic [REM_W-1:0]  dv_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [REM_W:0]    part;
    logic [REM_W:0]    diff;

    // restoring remainder, one dividend bit per cycle; divisor zero leaves the dividend
    always_comb
    begin
        part   = {r_reg, d_reg[REM_W-1]};
        diff   = part - {1'b0, dv_reg};
        r_next = (part >= {1'b0, dv_reg}) ? diff[REM_W-1:0] : part[REM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == STEP_W'(REM_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            r_reg  <= '0;
            d_reg  <= dividend;
            dv_reg <= divisor;
        end
        else if (busy_reg)
        begin
            r_reg <= r_next;
            d_reg <= {d_reg[REM_W-2:0], 1'b0};
        end
    end

    assign done = done_reg;
    assign rem  = r_reg;

endmodule

/* rtl/tfsp_dp.sv */
module tfsp_dp #(
    parameter int SLOTS = tfsp_pkg::SLOTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  tfsp_pkg::tfsp_cmd_t             cmd,
    output tfsp_pkg::tfsp_sts_t             sts,
    input  tfsp_pkg::tfsp_req_t             req,
    input  logic                            cfg_wr,
    input  logic [tfsp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tfsp_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output tfsp_pkg::tfsp_rsp_t             rsp
);
    import tfsp_pkg::*;

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int BW = $clog2(MAX_RES);

    logic [CFG_DATA_W-1:0] on_reg;
    logic [CFG_DATA_W-1:0] period_reg;
    logic [CFG_DATA_W-1:0] total_reg;

    logic [7:0]       key_reg   [SLOTS];
    logic [31:0]      start_reg [SLOTS];
    logic [SLOTS-1:0] green_reg;
    logic [SLOTS-1:0] active_reg;
    logic [SLOTS-1:0] live_reg;

    logic [1:0]  op_reg;
    logic [7:0]  key_cur_reg;
    logic        on_cur_reg;
    logic [31:0] now_cur_reg;

    logic [SW-1:0] cnt_reg;
    logic          match_found_reg;
    logic [SW-1:0] match_idx_reg;
    logic          free_found_reg;
    logic [SW-1:0] free_idx_reg;
    logic [SW-1:0] old_idx_reg;
    logic [31:0]   old_age_reg;

    tfsp_rsp_t        res_reg [MAX_RES];
    logic [RES_W-1:0] nres_reg;
    logic [BW-1:0]    ecnt_reg;
    logic             rsp_valid_reg;
    tfsp_rsp_t        rsp_reg;
    tfsp_rsp_t        rsp_next;

    logic [31:0]      age;
    logic             cur_act;
    logic             expired;
    logic             survivor;
    logic             cnt_last;
    logic [SW-1:0]    cnt_inc;
    logic [SW-1:0]    claim_idx;
    logic [SW+1:0]    cnt_ext;
    logic [SW+1:0]    claim_ext;
    logic             other_live;
    logic             emit_last;
    logic             out_free;
    logic             res_room;
    logic             rem_done;
    logic [REM_W-1:0] rem;
    logic             lit_now;

    always_comb
    begin
        age       = now_cur_reg - start_reg[cnt_reg];
        cur_act   = active_reg[cnt_reg];
        expired   = age >= {16'd0, total_reg};
        survivor  = cur_act && !expired;
        cnt_last  = cnt_reg == SW'(SLOTS - 1);
        cnt_inc   = cnt_last ? '0 : cnt_reg + 1'b1;
        claim_idx = match_found_reg ? match_idx_reg :
                    free_found_reg  ? free_idx_reg  : old_idx_reg;
        cnt_ext   = {2'b00, cnt_reg};
        claim_ext = {2'b00, claim_idx};
        other_live = 1'b0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (live_reg[i] && (SW'(i) != claim_idx))
            begin
                other_live = 1'b1;
            end
        end
        lit_now   = rem < on_reg;
        res_room  = nres_reg < RES_W'(MAX_RES);
        emit_last = {1'b0, ecnt_reg} == (nres_reg - RES_W'(1));
        out_free  = !rsp_valid_reg || !rsp_stall;
        rsp_next      = res_reg[ecnt_reg];
        rsp_next.last = emit_last;
    end

    tfsp_rem u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.rend_step && survivor),
        .dividend (age[REM_W-1:0]),
        .divisor  (period_reg),
        .done     (rem_done),
        .rem      (rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_reg          <= PULSE_ON_RST;
            period_reg      <= PULSE_PERIOD_RST;
            total_reg       <= FLASH_TOTAL_RST;
            active_reg      <= '0;
            op_reg          <= '0;
            cnt_reg         <= '0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            nres_reg        <= '0;
            ecnt_reg        <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                unique case (cfg_index)
                    CFG_PULSE_ON:     on_reg     <= cfg_data;
                    CFG_PULSE_PERIOD: period_reg <= cfg_data;
                    CFG_FLASH_TOTAL:  total_reg  <= cfg_data;
                    default:          ;
                endcase
            end
            if (cmd.load)
            begin
                op_reg          <= req.opcode;
                cnt_reg         <= '0;
                match_found_reg <= 1'b0;
                free_found_reg  <= 1'b0;
                nres_reg        <= '0;
                ecnt_reg        <= '0;
            end
            if (cmd.scan)
            begin
                if (cur_act && (key_reg[cnt_reg] == key_cur_reg))
                begin
                    match_found_reg <= 1'b1;
                end
                if (!cur_act)
                begin
                    free_found_reg <= 1'b1;
                end
                cnt_reg <= cnt_inc;
            end
            if (cmd.claim)
            begin
                active_reg[claim_idx] <= 1'b1;
                nres_reg              <= RES_W'(1);
            end
            if (cmd.query_done)
            begin
                nres_reg <= RES_W'(1);
            end
            if (cmd.rend_step)
            begin
                if (cur_act && expired)
                begin
                    active_reg[cnt_reg] <= 1'b0;
                end
                if (!survivor)
                begin
                    cnt_reg <= cnt_inc;
                end
            end
            if (cmd.rend_rec)
            begin
                cnt_reg <= cnt_inc;
                if (res_room)
                begin
                    nres_reg <= nres_reg + 1'b1;
                end
            end
            if (cmd.rend_done && (nres_reg == '0))
            begin
                nres_reg <= RES_W'(1);
            end
            if (cmd.emit)
            begin
                ecnt_reg      <= ecnt_reg + 1'b1;
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_cur_reg <= req.key_usage;
            on_cur_reg  <= req.turn_on;
            now_cur_reg <= req.now_ms;
            old_idx_reg <= '0;
            old_age_reg <= '0;
        end
        if (cmd.scan)
        begin
            if (cur_act && (key_reg[cnt_reg] == key_cur_reg) && !match_found_reg)
            begin
                match_idx_reg <= cnt_reg;
            end
            if (!cur_act && !free_found_reg)
            begin
                free_idx_reg <= cnt_reg;
            end
            // ties go to the later slot
            if (cur_act && (age >= old_age_reg))
            begin
                old_age_reg <= age;
                old_idx_reg <= cnt_reg;
            end
            live_reg[cnt_reg] <= survivor;
        end
        if (cmd.claim)
        begin
            key_reg[claim_idx]   <= key_cur_reg;
            green_reg[claim_idx] <= on_cur_reg;
            start_reg[claim_idx] <= now_cur_reg;
            res_reg[0] <= '{slot_index:    claim_ext[1:0],
                            key_usage_out: key_cur_reg,
                            lit:           1'b0,
                            green:         on_cur_reg,
                            any_active:    (total_reg != '0) || other_live,
                            last:          1'b0};
        end
        if (cmd.query_done)
        begin
            res_reg[0] <= '{slot_index:    2'd0,
                            key_usage_out: 8'd0,
                            lit:           1'b0,
                            green:         1'b0,
                            any_active:    |live_reg,
                            last:          1'b0};
        end
        if (cmd.rend_rec && res_room)
        begin
            res_reg[nres_reg[BW-1:0]] <= '{slot_index:    cnt_ext[1:0],
                                           key_usage_out: key_reg[cnt_reg],
                                           lit:           lit_now,
                                           green:         green_reg[cnt_reg],
                                           any_active:    1'b1,
                                           last:          1'b0};
        end
        if (cmd.rend_done && (nres_reg == '0))
        begin
            res_reg[0] <= '0;
        end
        if (cmd.emit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_comb
    begin
        sts.op        = op_reg;
        sts.cnt_last  = cnt_last;
        sts.survivor  = survivor;
        sts.rem_done  = rem_done;
        sts.out_free  = out_free;
        sts.emit_last = emit_last;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

/* rtl/tfsp_ctrl.sv */
module tfsp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic [1:0]          req_opcode,
    input  tfsp_pkg::tfsp_sts_t sts,
    output tfsp_pkg::tfsp_cmd_t cmd,
    output logic                req_stall
);
    import tfsp_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.load = 1'b1;
                    unique case (req_opcode) inside
                        OP_START, OP_QUERY: state_next = ST_SCAN;
                        OP_RENDER:          state_next = ST_RSTEP;
                        default:            state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.cnt_last)
                begin
                    state_next = (sts.op == OP_START) ? ST_CLAIM : ST_QDONE;
                end
            end
            ST_CLAIM:
            begin
                cmd.claim  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_QDONE:
            begin
                cmd.query_done = 1'b1;
                state_next     = ST_EMIT;
            end
            ST_RSTEP:
            begin
                cmd.rend_step = 1'b1;
                if (sts.survivor)
                begin
                    state_next = ST_RWAIT;
                end
                else if (sts.cnt_last)
                begin
                    state_next = ST_RDONE;
                end
            end
            ST_RWAIT:
            begin
                if (sts.rem_done)
                begin
                    cmd.rend_rec = 1'b1;
                    state_next   = sts.cnt_last ? ST_RDONE : ST_RSTEP;
                end
            end
            ST_RDONE:
            begin
                cmd.rend_done = 1'b1;
                state_next    = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/timed_flash_slot_pool.sv */
// Start and query: the request is loaded, every slot is scanned in turn, then a claim (start) or
// query close step builds the result. Render: slots are checked in turn; each live one waits on
// the 16-step serial remainder unit; after a close step, up to 4 results go to the output register.
// One request at a time; the next is taken once the last result sits in the output register.
// Reset (rst_n, async, active low): all slots free, pulse 150/280, window 560; no clear pass.
module timed_flash_slot_pool #(
    parameter int SLOTS = tfsp_pkg::SLOTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  tfsp_pkg::tfsp_req_t             req,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output tfsp_pkg::tfsp_rsp_t             rsp,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tfsp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tfsp_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tfsp_pkg::*;

    tfsp_cmd_t cmd;
    tfsp_sts_t sts;

    assign cfg_ready = 1'b1;

    tfsp_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_opcode (req.opcode),
        .sts        (sts),
        .cmd        (cmd),
        .req_stall  (req_stall)
    );

    tfsp_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .req       (req),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

/* rtl/tfsp_chk.sv */
module tfsp_chk (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_stall,
    input tfsp_pkg::tfsp_req_t req,
    input logic                rsp_valid,
    input logic                rsp_stall,
    input tfsp_pkg::tfsp_rsp_t rsp
);
    import tfsp_pkg::*;

    // stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled result changed");

    // a taken request with a real opcode blocks the next one
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall &&
        (req.opcode == OP_START || req.opcode == OP_RENDER || req.opcode == OP_QUERY)
        |=> req_stall)
        else $error("request taken while busy");

    // only render survivors are non-final, and they are always active
    a_mid_active: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.last |-> rsp.any_active)
        else $error("non-final result without active flash");

    a_idle_dark: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.any_active |-> !rsp.lit && rsp.last)
        else $error("inactive result lit or not final");

endmodule

bind timed_flash_slot_pool tfsp_chk u_chk (.*);

/* tb/sv/tb_timed_flash_slot_pool.sv */
module tb_timed_flash_slot_pool;

    import tfsp_pkg::*;

    localparam int POOL_SLOTS = SLOTS_DEF;
    localparam int RUN_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 120;
    localparam int HOLD_AT_REQ = 35;
    localparam int HOLD_CYCLES = 300;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    tfsp_req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    tfsp_rsp_t rsp;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    timed_flash_slot_pool uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // predicted pool state and timing registers
    logic [15:0] on_ms = PULSE_ON_RST;
    logic [15:0] period_ms = PULSE_PERIOD_RST;
    logic [15:0] total_ms = FLASH_TOTAL_RST;
    logic [7:0]  pool_key [POOL_SLOTS] = '{default: '0};
    logic        pool_green [POOL_SLOTS] = '{default: '0};
    logic        pool_active [POOL_SLOTS] = '{default: '0};
    logic [31:0] pool_start [POOL_SLOTS] = '{default: '0};

    tfsp_req_t req_backlog [$];
    tfsp_rsp_t flash_rsp_q [$];

    int unsigned req_taken;
    int unsigned req_gap;
    int unsigned rsp_seen;
    int unsigned rsp_hold;
    int unsigned bad_count = 0;
    int unsigned long_left;
    int unsigned cycle_count = 0;
    logic long_hold;
    logic long_done;
    logic [31:0] clock_ms = '0;
    logic [7:0] key_set [6] = '{8'h04, 8'h1e, 8'h2c, 8'h39, 8'h81, 8'he0};

    function automatic logic live_any(input logic [31:0] now);
        logic [31:0] age;
        for (int i = 0; i < POOL_SLOTS; i++)
        begin
            age = now - pool_start[i];
            if (pool_active[i] && age < {16'd0, total_ms})
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void predict_flash(input tfsp_req_t r);
        tfsp_rsp_t o;
        tfsp_rsp_t held;
        logic [31:0] age;
        logic [31:0] top_age;
        logic [31:0] ph;
        int slot;
        int oldest;
        int n;
        bit found;
        bit have;
        o = '0;
        case (r.opcode)
            OP_START:
            begin
                found = 1'b0;
                slot = 0;
                oldest = 0;
                top_age = '0;
                for (int i = 0; i < POOL_SLOTS; i++)
                    if (!found && pool_active[i] && pool_key[i] == r.key_usage)
                    begin
                        slot = i;
                        found = 1'b1;
                    end
                for (int i = 0; i < POOL_SLOTS; i++)
                    if (!found)
                    begin
                        if (!pool_active[i])
                        begin
                            slot = i;
                            found = 1'b1;
                        end
                        else
                        begin
                            age = r.now_ms - pool_start[i];
                            // ties go to the higher slot
                            if (age >= top_age)
                            begin
                                top_age = age;
                                oldest = i;
                            end
                        end
                    end
                if (!found)
                    slot = oldest;
                pool_key[slot] = r.key_usage;
                pool_green[slot] = r.turn_on;
                pool_active[slot] = 1'b1;
                pool_start[slot] = r.now_ms;
                o.slot_index = slot[1:0];
                o.key_usage_out = r.key_usage;
                o.green = r.turn_on;
                o.any_active = live_any(r.now_ms);
                o.last = 1'b1;
                flash_rsp_q.push_back(o);
            end
            OP_RENDER:
            begin
                n = 0;
                have = 1'b0;
                held = '0;
                for (int i = 0; i < POOL_SLOTS; i++)
                begin
                    if (pool_active[i])
                    begin
                        age = r.now_ms - pool_start[i];
                        if (age >= {16'd0, total_ms})
                            pool_active[i] = 1'b0;
                        else
                        begin
                            ph = (period_ms != 0) ? age % {16'd0, period_ms} : age;
                            if (n < MAX_RES)
                            begin
                                if (have)
                                    flash_rsp_q.push_back(held);
                                held = '0;
                                held.slot_index = i[1:0];
                                held.key_usage_out = pool_key[i];
                                held.lit = (ph < {16'd0, on_ms});
                                held.green = pool_green[i];
                                held.any_active = 1'b1;
                                have = 1'b1;
                                n++;
                            end
                        end
                    end
                end
                if (!have)
                    held = '0;
                held.last = 1'b1;
                flash_rsp_q.push_back(held);
            end
            OP_QUERY:
            begin
                o.any_active = live_any(r.now_ms);
                o.last = 1'b1;
                flash_rsp_q.push_back(o);
            end
            default:
            begin
            end
        endcase
    endfunction

    // short bursts with no idling every fourth group of 16
    function automatic int unsigned pause_len(input int unsigned count);
        if ((count / 16) % 4 == 3)
            return 0;
        return $urandom_range(0, 4);
    endfunction

    task automatic log_bad(input string what, input tfsp_rsp_t want);
        bad_count++;
        if (bad_count <= 10)
        begin
            $display("%0s at result %0d: expected idx=%0d key=%02h lit=%0b grn=%0b any=%0b last=%0b",
                     what, rsp_seen, want.slot_index, want.key_usage_out, want.lit,
                     want.green, want.any_active, want.last);
            $display("    got idx=%0d key=%02h lit=%0b grn=%0b any=%0b last=%0b",
                     rsp.slot_index, rsp.key_usage_out, rsp.lit, rsp.green,
                     rsp.any_active, rsp.last);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : drive_req
        int unsigned gap;
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
            req_gap <= 0;
            req_taken <= 0;
        end
        else if (req_valid && !req_stall)
        begin
            predict_flash(req);
            req_taken <= req_taken + 1;
            gap = pause_len(req_taken);
            if (gap == 0 && req_backlog.size() != 0)
                req <= req_backlog.pop_front();
            else
            begin
                req_valid <= 1'b0;
                req_gap <= gap;
            end
        end
        else if (!req_valid)
        begin
            if (req_gap != 0)
                req_gap <= req_gap - 1;
            else if (req_backlog.size() != 0)
            begin
                req <= req_backlog.pop_front();
                req_valid <= 1'b1;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : watch_rsp
        int unsigned hold;
        tfsp_rsp_t want;
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            rsp_hold <= 0;
            rsp_seen <= 0;
        end
        else
        begin
            hold = rsp_hold;
            if (rsp_valid && !rsp_stall)
            begin
                if (flash_rsp_q.size() == 0)
                    log_bad("unexpected result", '0);
                else
                begin
                    want = flash_rsp_q.pop_front();
                    if (rsp.slot_index !== want.slot_index ||
                        rsp.key_usage_out !== want.key_usage_out ||
                        rsp.lit !== want.lit || rsp.green !== want.green ||
                        rsp.any_active !== want.any_active || rsp.last !== want.last)
                        log_bad("wrong result", want);
                end
                rsp_seen <= rsp_seen + 1;
                hold = pause_len(rsp_seen);
            end
            else if (hold != 0)
                hold = hold - 1;
            rsp_hold <= hold;
            rsp_stall <= (hold != 0) || long_hold;
        end
    end

    // one long receiver hold-off so the pool backs up into the request side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_hold <= 1'b0;
            long_left <= 0;
            long_done <= 1'b0;
        end
        else if (!long_done && req_taken >= HOLD_AT_REQ)
        begin
            long_hold <= 1'b1;
            long_left <= HOLD_CYCLES;
            long_done <= 1'b1;
        end
        else if (long_left != 0)
        begin
            long_left <= long_left - 1;
            if (long_left == 1)
                long_hold <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("timed_flash_slot_pool: mismatch");
            $finish;
        end
    end

    task automatic push_req(input logic [1:0] op, input logic [7:0] key, input logic on,
                            input logic [31:0] now);
        tfsp_req_t r;
        r.opcode = op;
        r.key_usage = key;
        r.turn_on = on;
        r.now_ms = now;
        req_backlog.push_back(r);
    endtask

    task automatic settle();
        do
            @(negedge clk);
        while (req_backlog.size() != 0 || req_valid || flash_rsp_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(negedge clk);
        while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_PULSE_ON:     on_ms = val;
            CFG_PULSE_PERIOD: period_ms = val;
            CFG_FLASH_TOTAL:  total_ms = val;
            default:          ;
        endcase
    endtask

    task automatic set_timing(input logic [15:0] on, input logic [15:0] per,
                              input logic [15:0] tot);
        write_reg(CFG_PULSE_ON, on);
        write_reg(CFG_PULSE_PERIOD, per);
        write_reg(CFG_FLASH_TOTAL, tot);
    endtask

    task automatic random_burst(input int n);
        int unsigned pick;
        int unsigned span;
        logic [7:0] k;
        span = (total_ms == 0) ? 8 : total_ms / 3 + 1;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 49) == 0)
                clock_ms = 32'hffff_ffff - $urandom_range(0, span);
            else
                clock_ms += $urandom_range(0, span);
            k = ($urandom_range(0, 3) == 0) ? 8'($urandom) : key_set[$urandom_range(0, 5)];
            if (pick < 45)
                push_req(OP_START, k, 1'($urandom), clock_ms);
            else if (pick < 78)
                push_req(OP_RENDER, 8'($urandom), 1'($urandom), clock_ms);
            else if (pick < 90)
                push_req(OP_QUERY, 8'($urandom), 1'($urandom), clock_ms);
            else if (pick < 94)
            begin
                push_req(OP_UNUSED, 8'($urandom), 1'($urandom), $urandom);
                i--;
            end
            else
                push_req(2'($urandom_range(0, 2)), 8'($urandom), 1'($urandom), $urandom);
        end
    endtask

    initial
    begin
        push_req(OP_QUERY, 8'h00, 1'b0, 32'd0);
        push_req(OP_RENDER, 8'h00, 1'b0, 32'd0);
        push_req(OP_UNUSED, 8'hff, 1'b1, 32'd5);
        push_req(OP_START, 8'h00, 1'b0, 32'd100);
        push_req(OP_START, 8'hff, 1'b1, 32'd110);
        push_req(OP_START, 8'haa, 1'b1, 32'd120);
        push_req(OP_START, 8'h55, 1'b0, 32'd130);
        push_req(OP_START, 8'hff, 1'b0, 32'd140);
        push_req(OP_START, 8'h11, 1'b1, 32'd150);
        push_req(OP_RENDER, 8'h00, 1'b0, 32'd300);
        push_req(OP_RENDER, 8'h00, 1'b0, 32'd560);
        push_req(OP_QUERY, 8'h00, 1'b0, 32'd709);
        push_req(OP_QUERY, 8'h00, 1'b0, 32'd710);
        push_req(OP_RENDER, 8'h00, 1'b0, 32'd710);
        push_req(OP_START, 8'h01, 1'b1, 32'd1000);
        push_req(OP_START, 8'h02, 1'b0, 32'd1000);
        push_req(OP_START, 8'h03, 1'b1, 32'd1000);
        push_req(OP_START, 8'h04, 1'b0, 32'd1000);
        push_req(OP_START, 8'h05, 1'b1, 32'd1000);
        push_req(OP_RENDER, 8'h00, 1'b0, 32'd1000);
        push_req(OP_START, 8'h09, 1'b1, 32'hffff_fff0);
        push_req(OP_RENDER, 8'h00, 1'b0, 32'h0000_0010);
        push_req(OP_QUERY, 8'hff, 1'b1, 32'hffff_ffff);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        settle();
        clock_ms = 32'd5000;
        random_burst(30);
        settle();
        set_timing(16'd1, 16'd65535, 16'd65535);
        random_burst(25);
        settle();
        set_timing(16'd65535, 16'd1, 16'd1);
        random_burst(20);
        settle();
        set_timing(16'd0, 16'd0, 16'd0);
        random_burst(15);
        settle();
        set_timing(16'd30, 16'd0, 16'd200);
        random_burst(20);
        for (int p = 0; p < 2; p++)
        begin
            settle();
            set_timing(16'($urandom_range(1, 100)), 16'($urandom_range(1, 200)),
                       16'($urandom_range(50, 600)));
            random_burst(25);
        end
        settle();
        if (bad_count == 0 && flash_rsp_q.size() == 0)
            $display("timed_flash_slot_pool: match");
        else
            $display("timed_flash_slot_pool: mismatch");
        $finish;
    end

endmodule

/* files.f */
rtl/tfsp_pkg.sv
rtl/tfsp_rem.sv
rtl/tfsp_dp.sv
rtl/tfsp_ctrl.sv
rtl/timed_flash_slot_pool.sv
rtl/tfsp_chk.sv
tb/sv/tb_timed_flash_slot_pool.sv
